@@ sv/fpfa_pkg.sv @@
// ----------------------------------------------------------------------------
// fpfa_pkg
// Shared types and constants for the fixed partition fit allocator.
// ----------------------------------------------------------------------------
package fpfa_pkg;

    // payload field widths
    localparam int ACTION_W = 2;
    localparam int SLOT_W   = 6;
    localparam int AMOUNT_W = 16;
    localparam int LEFT_W   = 16;
    localparam int TOTAL_W  = 22;
    localparam int POLICY_W = 2;
    localparam int PARTS_W  = 7;

    // apb register map
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [APB_AW-1:0] ADDR_FIT_POLICY      = 3'h0;
    localparam logic [APB_AW-1:0] ADDR_PARTS_IN_USE    = 3'h4;

    localparam logic [POLICY_W-1:0] FIT_POLICY_RST     = 2'd0;
    localparam logic [PARTS_W-1:0]  PARTS_IN_USE_RST   = 7'd64;

    localparam logic [TOTAL_W-1:0]  TOTAL_MAX          = 22'h3FFFFF;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_LOAD    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_RESTART = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REQUEST = 2'd2;

    // fit policy codes, anything else behaves as first fit
    localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPLY,
        ST_SCAN,
        ST_DRAIN,
        ST_UPDATE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic apply;
        logic scan_issue;
        logic update;
        logic out_load;
    } t_ctrl_cmd;

    typedef struct packed {
        logic last_issue;
        logic out_free;
    } t_ctrl_sts;

endpackage

@@ sv/fpfa_if.sv @@
// ----------------------------------------------------------------------------
// fpfa_in_if / fpfa_out_if
// Valid/ready channels for allocator actions and their results.
// ----------------------------------------------------------------------------
interface fpfa_in_if
    import fpfa_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [SLOT_W-1:0]   slot_index;
    logic [AMOUNT_W-1:0] amount;

    modport source (output valid, output action, output slot_index, output amount,
                    input ready);
    modport sink   (input valid, input action, input slot_index, input amount,
                    output ready);
endinterface

interface fpfa_out_if
    import fpfa_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               granted;
    logic [SLOT_W-1:0]  chosen_slot;
    logic [LEFT_W-1:0]  leftover;
    logic [TOTAL_W-1:0] total_free;

    modport source (output valid, output granted, output chosen_slot, output leftover,
                    output total_free, input ready);
    modport sink   (input valid, input granted, input chosen_slot, input leftover,
                    input total_free, output ready);
endinterface

@@ sv/fpfa_ram.sv @@
// ----------------------------------------------------------------------------
// fpfa_ram
// Generic single write port, single read port ram with registered read.
// ----------------------------------------------------------------------------
module fpfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ sv/fpfa_ctrl.sv @@
// ----------------------------------------------------------------------------
// fpfa_ctrl
// Sequencer: takes one action, runs the table scan and releases the result.
// ----------------------------------------------------------------------------
module fpfa_ctrl
    import fpfa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_ctrl_sts i_sts,
    output t_ctrl_cmd o_cmd
);
    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_APPLY;
                end
            end
            ST_APPLY:  n_state = ST_SCAN;
            ST_SCAN: begin
                if (i_sts.last_issue) begin
                    n_state = ST_DRAIN;
                end
            end
            // last read still in flight
            ST_DRAIN:  n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_DONE;
            ST_DONE: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_APPLY:  o_cmd.apply      = 1'b1;
            ST_SCAN:   o_cmd.scan_issue = 1'b1;
            ST_DRAIN:  o_cmd            = '0;
            ST_UPDATE: o_cmd.update     = 1'b1;
            ST_DONE:   o_cmd.out_load   = i_sts.out_free;
            default:   o_cmd            = '0;
        endcase
    end
endmodule

@@ sv/fpfa_dp.sv @@
// ----------------------------------------------------------------------------
// fpfa_dp
// Partition table, fit search over one entry per cycle and result register.
// ----------------------------------------------------------------------------
module fpfa_dp
    import fpfa_pkg::*;
#(
    parameter int MAX_PARTITIONS = 64,
    parameter int SIZE_BITS      = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_ctrl_cmd           i_cmd,
    output t_ctrl_sts           o_sts,
    input  logic [POLICY_W-1:0] i_fit_policy,
    input  logic [PARTS_W-1:0]  i_parts_in_use,
    input  logic [ACTION_W-1:0] i_action,
    input  logic [SLOT_W-1:0]   i_slot_index,
    input  logic [AMOUNT_W-1:0] i_amount,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic                o_granted,
    output logic [SLOT_W-1:0]   o_chosen_slot,
    output logic [LEFT_W-1:0]   o_leftover,
    output logic [TOTAL_W-1:0]  o_total_free
);
    localparam int AW    = $clog2(MAX_PARTITIONS);
    localparam int CW    = $clog2(MAX_PARTITIONS + 1);
    localparam int ACC_W = SIZE_BITS + CW;

    logic [ACTION_W-1:0]       r_action;
    logic [SLOT_W-1:0]         r_slot;
    logic [SIZE_BITS-1:0]      r_amt;
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             r_scan_addr;
    logic                      r_rd_vld;
    logic [AW-1:0]             r_rd_idx;
    logic                      r_found;
    logic [AW-1:0]             r_pick;
    logic [SIZE_BITS-1:0]      r_best;
    logic [ACC_W-1:0]          r_acc;
    logic [MAX_PARTITIONS-1:0] r_taken;
    logic [MAX_PARTITIONS-1:0] r_rem_mod;
    logic [MAX_PARTITIONS-1:0] r_orig_vld;
    logic                      r_out_valid;
    logic                      r_granted;
    logic [SLOT_W-1:0]         r_chosen;
    logic [LEFT_W-1:0]         r_left;
    logic [TOTAL_W-1:0]        r_total;

    logic [CW-1:0]             count_clamped;
    logic                      slot_ok;
    logic [AW-1:0]             slot_addr;
    logic                      load_we;
    logic                      grant_we;
    logic [SIZE_BITS-1:0]      orig_q;
    logic [SIZE_BITS-1:0]      rem_q;
    logic [SIZE_BITS-1:0]      scan_sz;
    logic                      fits;
    logic                      take;
    logic [SIZE_BITS-1:0]      new_rem;
    logic [ACC_W-1:0]          total_diff;
    logic [TOTAL_W-1:0]        total_sat;

    always_comb begin
        if (i_parts_in_use == '0) begin
            count_clamped = CW'(1);
        end else if (32'(i_parts_in_use) > 32'(MAX_PARTITIONS)) begin
            count_clamped = CW'(MAX_PARTITIONS);
        end else begin
            count_clamped = CW'(i_parts_in_use);
        end
    end

    assign slot_ok   = 32'(r_slot) < 32'(MAX_PARTITIONS);
    assign slot_addr = AW'(r_slot);
    assign load_we   = i_cmd.apply && (r_action == ACT_LOAD) && slot_ok;
    assign grant_we  = i_cmd.update && (r_action == ACT_REQUEST) && r_found;
    assign new_rem   = r_best - r_amt;

    fpfa_ram #(.WIDTH(SIZE_BITS), .DEPTH(MAX_PARTITIONS)) u_orig_ram (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (slot_addr),
        .i_wdata (r_amt),
        .i_re    (i_cmd.scan_issue),
        .i_raddr (r_scan_addr[AW-1:0]),
        .o_rdata (orig_q)
    );

    fpfa_ram #(.WIDTH(SIZE_BITS), .DEPTH(MAX_PARTITIONS)) u_rem_ram (
        .i_clk   (i_clk),
        .i_we    (grant_we),
        .i_waddr (r_pick),
        .i_wdata (new_rem),
        .i_re    (i_cmd.scan_issue),
        .i_raddr (r_scan_addr[AW-1:0]),
        .o_rdata (rem_q)
    );

    // remaining size follows the original until a grant overwrites it
    always_comb begin
        if (r_rem_mod[r_rd_idx]) begin
            scan_sz = rem_q;
        end else if (r_orig_vld[r_rd_idx]) begin
            scan_sz = orig_q;
        end else begin
            scan_sz = '0;
        end
    end

    assign fits = (r_action == ACT_REQUEST) && !r_taken[r_rd_idx] && (r_amt <= scan_sz);

    always_comb begin
        take = 1'b0;
        if (fits) begin
            if (!r_found) begin
                take = 1'b1;
            end else if (i_fit_policy == POL_BEST) begin
                take = scan_sz < r_best;
            end else if (i_fit_policy == POL_WORST) begin
                take = scan_sz > r_best;
            end
        end
    end

    assign total_diff = r_acc - (r_found ? ACC_W'(r_amt) : ACC_W'(0));
    assign total_sat  = (64'(total_diff) > 64'(TOTAL_MAX)) ? TOTAL_MAX
                                                           : TOTAL_W'(total_diff);

    // item capture and scan datapath
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= i_action;
            r_slot   <= i_slot_index;
            r_amt    <= SIZE_BITS'(i_amount);
        end
        if (i_cmd.apply) begin
            r_count     <= count_clamped;
            r_scan_addr <= '0;
            r_acc       <= '0;
        end else if (i_cmd.scan_issue) begin
            r_scan_addr <= r_scan_addr + CW'(1);
        end
        r_rd_idx <= r_scan_addr[AW-1:0];
        if (r_rd_vld) begin
            r_acc <= r_acc + ACC_W'(scan_sz);
            if (take) begin
                r_pick <= r_rd_idx;
                r_best <= scan_sz;
            end
        end
    end

    // control bits and per-entry flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld   <= 1'b0;
            r_found    <= 1'b0;
            r_taken    <= '0;
            r_rem_mod  <= '0;
            r_orig_vld <= '0;
        end else begin
            r_rd_vld <= i_cmd.scan_issue;
            if (i_cmd.apply) begin
                r_found <= 1'b0;
            end else if (r_rd_vld && take) begin
                r_found <= 1'b1;
            end
            if (load_we) begin
                r_orig_vld[slot_addr] <= 1'b1;
                r_rem_mod[slot_addr]  <= 1'b0;
            end
            if (i_cmd.apply && (r_action == ACT_RESTART)) begin
                r_rem_mod <= '0;
                r_taken   <= '0;
            end
            if (grant_we) begin
                r_taken[r_pick]   <= 1'b1;
                r_rem_mod[r_pick] <= 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_granted <= r_found;
            r_chosen  <= r_found ? SLOT_W'(r_pick) : '0;
            r_left    <= r_found ? LEFT_W'(new_rem) : '0;
            r_total   <= total_sat;
        end
    end

    assign o_sts.last_issue = r_scan_addr == (r_count - CW'(1));
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_granted     = r_granted;
    assign o_chosen_slot = r_chosen;
    assign o_leftover    = r_left;
    assign o_total_free  = r_total;
endmodule

@@ sv/fixed_partition_fit_allocator.sv @@
// ----------------------------------------------------------------------------
// fixed_partition_fit_allocator
// Fixed partition allocator with first, best and worst fit placement.
// ----------------------------------------------------------------------------
// Every action (load, restart, request) gives one result. The table is read
// one entry per cycle through the registered read port of the size memories,
// both to find the fit and to sum total_free. An action passes through the
// apply, scan, drain, update and done states; the result is offered from the
// output register and the next action is taken back in the idle state.
// One action is in flight at a time; a finished result sits in the output
// register, and the block waits only when a second result is ready before the
// first has been taken. Restart and reset take effect at once through
// per-entry flag bits, so no clearing pass is needed.
module fixed_partition_fit_allocator
    import fpfa_pkg::*;
#(
    parameter int MAX_PARTITIONS = 64,
    parameter int SIZE_BITS      = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    fpfa_in_if.sink           i_item,
    fpfa_out_if.source        o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);
    logic [POLICY_W-1:0] r_fit_policy;
    logic [PARTS_W-1:0]  r_parts_in_use;
    logic                cfg_we;
    t_ctrl_cmd           cmd;
    t_ctrl_sts           sts;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_policy   <= FIT_POLICY_RST;
            r_parts_in_use <= PARTS_IN_USE_RST;
        end else if (cfg_we) begin
            case (paddr)
                ADDR_FIT_POLICY:   r_fit_policy   <= pwdata[POLICY_W-1:0];
                ADDR_PARTS_IN_USE: r_parts_in_use <= pwdata[PARTS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            ADDR_FIT_POLICY:   prdata = APB_DW'(r_fit_policy);
            ADDR_PARTS_IN_USE: prdata = APB_DW'(r_parts_in_use);
            default:           prdata = '0;
        endcase
    end

    fpfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (i_item.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    fpfa_dp #(
        .MAX_PARTITIONS (MAX_PARTITIONS),
        .SIZE_BITS      (SIZE_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_fit_policy   (r_fit_policy),
        .i_parts_in_use (r_parts_in_use),
        .i_action       (i_item.action),
        .i_slot_index   (i_item.slot_index),
        .i_amount       (i_item.amount),
        .i_out_ready    (o_result.ready),
        .o_out_valid    (o_result.valid),
        .o_granted      (o_result.granted),
        .o_chosen_slot  (o_result.chosen_slot),
        .o_leftover     (o_result.leftover),
        .o_total_free   (o_result.total_free)
    );
endmodule

@@ sv/fpfa_checker.sv @@
// ----------------------------------------------------------------------------
// fpfa_checker
// Port-level checks for the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module fpfa_checker
    import fpfa_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic               i_granted,
    input logic [SLOT_W-1:0]  i_chosen_slot,
    input logic [LEFT_W-1:0]  i_leftover,
    input logic [TOTAL_W-1:0] i_total_free
);
    // an action holds the input side for the whole scan
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready ##1 !i_in_ready ##1 !i_in_ready
                                     ##1 !i_in_ready)
        else $error("input accepted again before the scan could finish");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_granted)
            && $stable(i_chosen_slot) && $stable(i_leftover) && $stable(i_total_free))
        else $error("stalled result changed");

    // a new result only appears while the input side is closed
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result appeared without an action in progress");

    a_no_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_granted |-> (i_chosen_slot == '0) && (i_leftover == '0))
        else $error("refused request reports a slot or leftover");
endmodule

bind fixed_partition_fit_allocator fpfa_checker u_fpfa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_item.valid),
    .i_in_ready    (i_item.ready),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_granted     (o_result.granted),
    .i_chosen_slot (o_result.chosen_slot),
    .i_leftover    (o_result.leftover),
    .i_total_free  (o_result.total_free)
);

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the fixed partition fit allocator. A queue of
// load, restart and request actions feeds a valid/ready driver; each transfer
// runs through a local model of the partition table and the expected result
// is queued for the monitor, which checks every returned field in order.
// Phases step through all fit policies, a set of partition counts and idle patterns.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import fpfa_pkg::*;

    localparam int NUM_PARTS      = 64;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int ROUND_ITEMS    = 220;
    localparam int NUM_ROUNDS     = 8;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam logic [POLICY_W-1:0] POL_SPARE  = 2'd3;
    localparam logic [AMOUNT_W-1:0] SIZE_MAX   = 16'hFFFF;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [SLOT_W-1:0]   slot_index;
        logic [AMOUNT_W-1:0] amount;
    } t_alloc_action;

    typedef struct packed {
        logic               granted;
        logic [SLOT_W-1:0]  chosen_slot;
        logic [LEFT_W-1:0]  leftover;
        logic [TOTAL_W-1:0] total_free;
    } t_alloc_result;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [APB_AW-1:0] paddr   = '0;
    logic [APB_DW-1:0] pwdata  = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    fpfa_in_if  item_if ();
    fpfa_out_if result_if ();

    fixed_partition_fit_allocator u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if.sink),
        .o_result (result_if.source),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial forever #5 i_clk = ~i_clk;

    // model of the partition table
    logic [AMOUNT_W-1:0] part_size  [NUM_PARTS] = '{default: '0};
    logic [AMOUNT_W-1:0] part_left  [NUM_PARTS] = '{default: '0};
    bit                  part_taken [NUM_PARTS] = '{default: 1'b0};
    logic [POLICY_W-1:0] cur_policy = FIT_POLICY_RST;
    logic [PARTS_W-1:0]  cur_parts  = PARTS_IN_USE_RST;

    // sizes as loaded by the generator, used to aim requests at real fits
    logic [AMOUNT_W-1:0] gen_size [NUM_PARTS] = '{default: '0};

    t_alloc_action pending_actions [$];
    t_alloc_result expected_results [$];
    t_alloc_action bus_item;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int errors         = 0;
    int actions_sent   = 0;
    int results_seen   = 0;
    int grants_seen    = 0;
    int idle_cycles    = 0;

    function automatic int active_parts();
        int n;
        n = cur_parts;
        if (n < 1) n = 1;
        if (n > NUM_PARTS) n = NUM_PARTS;
        return n;
    endfunction

    function automatic t_alloc_result apply_action(t_alloc_action a);
        t_alloc_result r;
        int            n;
        int            pick;
        bit            found;
        logic [23:0]   sum;
        r     = '0;
        n     = active_parts();
        pick  = 0;
        found = 1'b0;
        sum   = '0;
        case (a.action)
            ACT_LOAD: begin
                part_size[a.slot_index] = a.amount;
                part_left[a.slot_index] = a.amount;
            end
            ACT_RESTART: begin
                for (int k = 0; k < NUM_PARTS; k++) begin
                    part_left[k]  = part_size[k];
                    part_taken[k] = 1'b0;
                end
            end
            ACT_REQUEST: begin
                for (int k = 0; k < n; k++) begin
                    if (!part_taken[k] && a.amount <= part_left[k]) begin
                        if (!found) begin
                            found = 1'b1;
                            pick  = k;
                            // first fit, and the spare code, stop at the first hit
                            if (cur_policy != POL_BEST && cur_policy != POL_WORST) break;
                        end else if (cur_policy == POL_BEST &&
                                     part_left[k] < part_left[pick]) begin
                            pick = k;
                        end else if (cur_policy == POL_WORST &&
                                     part_left[k] > part_left[pick]) begin
                            pick = k;
                        end
                    end
                end
                if (found) begin
                    part_left[pick]  = part_left[pick] - a.amount;
                    part_taken[pick] = 1'b1;
                    r.granted        = 1'b1;
                    r.chosen_slot    = SLOT_W'(pick);
                    r.leftover       = part_left[pick];
                end
            end
            default: ;
        endcase
        for (int k = 0; k < n; k++) sum += part_left[k];
        r.total_free = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[TOTAL_W-1:0];
        return r;
    endfunction

    // driver: one action on the bus at a time, random gaps between transfers
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_if.valid      <= 1'b0;
            item_if.action     <= ACT_LOAD;
            item_if.slot_index <= '0;
            item_if.amount     <= '0;
        end else if (!item_if.valid || item_if.ready) begin
            if (item_if.valid) begin
                expected_results.push_back(apply_action(bus_item));
                actions_sent++;
            end
            if (pending_actions.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                bus_item            = pending_actions.pop_front();
                item_if.valid      <= 1'b1;
                item_if.action     <= bus_item.action;
                item_if.slot_index <= bus_item.slot_index;
                item_if.amount     <= bus_item.amount;
            end else begin
                item_if.valid <= 1'b0;
            end
        end
    end

    // monitor: check each result against the oldest expectation
    always @(posedge i_clk) begin
        t_alloc_result got;
        t_alloc_result want;
        if (!i_rst_n) begin
            result_if.ready <= 1'b0;
        end else begin
            if (result_if.valid && result_if.ready) begin
                got = '{result_if.granted, result_if.chosen_slot, result_if.leftover,
                        result_if.total_free};
                results_seen++;
                if (got.granted) grants_seen++;
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%t: result with nothing expected: granted %0d slot %0d",
                             $realtime, got.granted, got.chosen_slot);
                    $display("%t:   left %0d total %0d",
                             $realtime, got.leftover, got.total_free);
                end else begin
                    want = expected_results.pop_front();
                    if (got.granted !== want.granted || got.chosen_slot !== want.chosen_slot ||
                        got.leftover !== want.leftover || got.total_free !== want.total_free) begin
                        errors++;
                        $display("%t: mismatch exp granted %0d slot %0d left %0d total %0d",
                                 $realtime, want.granted, want.chosen_slot, want.leftover,
                                 want.total_free);
                        $display("%t:          got granted %0d slot %0d left %0d total %0d",
                                 $realtime, got.granted, got.chosen_slot, got.leftover,
                                 got.total_free);
                    end
                end
            end
            result_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready) ||
            (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%t: no transfer for %0d cycles", $realtime, WATCHDOG_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic reg_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr == ADDR_FIT_POLICY) cur_policy = data[POLICY_W-1:0];
        else if (addr == ADDR_PARTS_IN_USE) cur_parts = data[PARTS_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input logic [POLICY_W-1:0] policy,
                              input logic [PARTS_W-1:0] parts);
        reg_write(ADDR_FIT_POLICY, APB_DW'(policy));
        reg_write(ADDR_PARTS_IN_USE, APB_DW'(parts));
    endtask

    task automatic queue_action(input logic [ACTION_W-1:0] act, input int slot, input int amt);
        t_alloc_action a;
        a.action     = act;
        a.slot_index = SLOT_W'(slot);
        a.amount     = AMOUNT_W'(amt);
        if (act == ACT_LOAD) gen_size[a.slot_index] = a.amount;
        pending_actions.push_back(a);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_actions.size() != 0 || item_if.valid || expected_results.size() != 0)
            @(negedge i_clk);
    endtask

    function automatic int pick_size();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return SIZE_MAX;
            2, 3:    return $urandom_range(1, 300);
            default: return $urandom_range(0, SIZE_MAX);
        endcase
    endfunction

    // mostly load / restart / request sequences, with some noise mixed in
    task automatic queue_round(input int count);
        int n;
        int made;
        int loads;
        int reqs;
        int slot;
        n    = active_parts();
        made = 0;
        while (made < count) begin
            case ($urandom_range(0, 9))
                7: begin
                    queue_action(ACT_RESTART, $urandom_range(0, 63), $urandom_range(0, SIZE_MAX));
                    made++;
                end
                8: queue_action(ACT_UNUSED, $urandom_range(0, 63), $urandom_range(0, SIZE_MAX));
                9: begin
                    queue_action(ACT_LOAD, $urandom_range(0, 63), pick_size());
                    made++;
                end
                default: begin
                    loads = $urandom_range(1, (n < 8) ? n : 8);
                    for (int k = 0; k < loads; k++)
                        queue_action(ACT_LOAD, $urandom_range(0, n - 1), pick_size());
                    if ($urandom_range(0, 9) < 8)
                        queue_action(ACT_RESTART, $urandom_range(0, 63),
                                     $urandom_range(0, SIZE_MAX));
                    reqs = $urandom_range(1, ((n < 8) ? n : 8) + 2);
                    for (int k = 0; k < reqs; k++) begin
                        slot = $urandom_range(0, n - 1);
                        case ($urandom_range(0, 19))
                            0, 1:    queue_action(ACT_REQUEST, slot, $urandom_range(0, SIZE_MAX));
                            2:       queue_action(ACT_REQUEST, slot, 0);
                            3:       queue_action(ACT_REQUEST, slot, SIZE_MAX);
                            4:       queue_action(ACT_REQUEST, slot, gen_size[slot]);
                            default: queue_action(ACT_REQUEST, slot,
                                                  $urandom_range(0, gen_size[slot]));
                        endcase
                    end
                    made += loads + reqs + 1;
                end
            endcase
        end
    endtask

    initial begin
        logic [POLICY_W-1:0] round_policy [NUM_ROUNDS];
        logic [PARTS_W-1:0]  round_parts  [NUM_ROUNDS];
        round_policy = '{POL_FIRST, POL_BEST, POL_WORST, POL_SPARE,
                         POL_BEST, POL_WORST, POL_FIRST, POL_BEST};
        round_parts  = '{7'd64, 7'd8, 7'd16, 7'd1, 7'd127, 7'd0, 7'd3, 7'd40};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: first fit over the full table
        set_config(POL_FIRST, 7'd64);
        queue_action(ACT_LOAD, 0, 100);
        queue_action(ACT_LOAD, 1, 0);
        queue_action(ACT_LOAD, 2, SIZE_MAX);
        queue_action(ACT_LOAD, 3, 100);
        queue_action(ACT_LOAD, 63, SIZE_MAX);
        queue_action(ACT_RESTART, 0, 0);
        queue_action(ACT_REQUEST, 0, 100);
        queue_action(ACT_REQUEST, 0, 0);
        queue_action(ACT_REQUEST, 63, SIZE_MAX);
        queue_action(ACT_REQUEST, 0, SIZE_MAX);
        queue_action(ACT_REQUEST, 0, 1);
        queue_action(ACT_REQUEST, 0, 1);
        // reload of a taken partition must leave it taken
        queue_action(ACT_LOAD, 0, 500);
        queue_action(ACT_REQUEST, 0, 400);
        queue_action(ACT_UNUSED, 63, SIZE_MAX);
        queue_action(ACT_RESTART, 63, SIZE_MAX);
        wait_drained();

        set_config(POL_BEST, 7'd64);
        queue_action(ACT_REQUEST, 0, 50);
        queue_action(ACT_REQUEST, 0, 50);
        wait_drained();

        // equal sizes in slots 2, 4 and 63: lowest index wins
        set_config(POL_WORST, 7'd64);
        queue_action(ACT_LOAD, 4, SIZE_MAX);
        queue_action(ACT_RESTART, 0, 0);
        queue_action(ACT_REQUEST, 0, 1);
        wait_drained();

        // spare policy code with a zero count clamps to one partition, first fit
        set_config(POL_SPARE, 7'd0);
        queue_action(ACT_REQUEST, 0, 0);
        queue_action(ACT_REQUEST, 0, 0);
        wait_drained();

        for (int r = 0; r < NUM_ROUNDS; r++) begin
            set_config(round_policy[r], round_parts[r]);
            case (r % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            @(negedge i_clk);
            queue_round(ROUND_ITEMS);
            wait_drained();
        end

        repeat (80) @(posedge i_clk);
        if (expected_results.size() != 0) errors++;
        $display("ran %0d actions over all fit policies and partition counts, %0d results checked",
                 actions_sent, results_seen);
        $display("%0d requests granted, %0d failures", grants_seen, errors);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ fixed_partition_fit_allocator.f @@
sv/fpfa_pkg.sv
sv/fpfa_if.sv
sv/fpfa_ram.sv
sv/fpfa_ctrl.sv
sv/fpfa_dp.sv
sv/fixed_partition_fit_allocator.sv
sv/fpfa_checker.sv
bench/testbench.sv
